@@ rtl/estp_pkg.sv @@
package estp_pkg;

	// Field widths of the item, result and register beats.
	localparam int unsigned LEVEL_W   = 10;
	localparam int unsigned INDEX_W   = 13;
	localparam int unsigned RADDR_W   = INDEX_W + 1;
	localparam int unsigned TONE_W    = 20;
	localparam int unsigned SUSTAIN_W = 26;
	localparam int unsigned EADDR_W   = 12;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [LEVEL_W-1:0]  FULL_LEVEL     = 10'd1023;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd1600;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_ENV_LENGTH    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_NOTE  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [TONE_W-1:0]    high_count;
		logic [TONE_W-1:0]    low_count;
		logic [SUSTAIN_W-1:0] sustain_ticks;
		logic [EADDR_W-1:0]   entry_addr;
		logic [LEVEL_W-1:0]   entry_level;
		logic                 entry_marker;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] dac_level;
		logic               tone_high;
		logic [INDEX_W-1:0] envelope_position;
	} result_t;

	// One envelope table entry.
	typedef struct packed {
		logic               marker;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	// The two entries around the current envelope index.
	typedef struct packed {
		entry_t cur;
		entry_t nxt;
	} env_pair_t;

endpackage

@@ rtl/enveloped_square_tone_player_core.sv @@
// Output: the result beat of an accepted item is registered in the output buffer.
// Throughput: one item per cycle while item_ready is high; the envelope table is read
// with the next index each cycle, so both entries around it are in registers for the
// following tick. Output stalls are absorbed by a two-beat buffer before item_ready drops.
// Reset: asynchronous, active low; timers, note counts and registers take their reset
// values at once. The envelope table is not cleared and must be written before use.
module enveloped_square_tone_player_core import estp_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [INDEX_W-1:0]   env_len_q;
	logic [PERIOD_W-1:0]  period_q;
	logic                 phase_q;
	logic [TONE_W-1:0]    tone_cnt_q;
	logic [TONE_W-1:0]    note_high_q;
	logic [TONE_W-1:0]    note_low_q;
	logic [SUSTAIN_W-1:0] note_sus_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [SUSTAIN_W-1:0] env_cnt_q;
	logic [LEVEL_W-1:0]   level_q;

	logic                 phase_n;
	logic [TONE_W-1:0]    tone_cnt_n;
	logic [INDEX_W-1:0]   idx_n;
	logic [SUSTAIN_W-1:0] env_cnt_n;
	logic [LEVEL_W-1:0]   level_n;
	logic [LEVEL_W-1:0]   cur_level;
	logic                 idx_active;
	logic                 hold;
	logic                 acc;
	env_pair_t            pair;
	result_t              res_n;

	assign acc        = item_valid && item_ready;
	assign idx_active = idx_q < env_len_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_len_q <= '0;
			period_q  <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENV_LENGTH:    env_len_q <= cfg_data[INDEX_W-1:0];
				CFG_SAMPLE_PERIOD: period_q  <= cfg_data[PERIOD_W-1:0];
				default:           ;
			endcase
		end
	end

	// Envelope level at the current index.
	always_comb begin
		if (env_len_q <= INDEX_W'(1)) begin
			cur_level = FULL_LEVEL;
		end else if (!idx_active) begin
			cur_level = '0;
		end else if (pair.cur.marker) begin
			cur_level = pair.nxt.level;
		end else begin
			cur_level = pair.cur.level;
		end
	end

	assign hold = idx_active && pair.cur.marker && (note_sus_q != '0);

	// Next state of both timers, the phase, the level and the index for the accepted item.
	always_comb begin
		phase_n    = phase_q;
		tone_cnt_n = tone_cnt_q;
		level_n    = level_q;
		idx_n      = idx_q;
		env_cnt_n  = env_cnt_q;
		if (acc) begin
			case (item.op)
				OP_TICK: begin
					if (tone_cnt_q <= TONE_W'(1)) begin
						if (phase_q) begin
							level_n    = cur_level;
							phase_n    = 1'b0;
							tone_cnt_n = note_high_q;
						end else begin
							level_n    = '0;
							phase_n    = 1'b1;
							tone_cnt_n = note_low_q;
						end
					end else begin
						tone_cnt_n = tone_cnt_q - TONE_W'(1);
					end
					if (env_cnt_q <= SUSTAIN_W'(1)) begin
						env_cnt_n = hold ? note_sus_q : SUSTAIN_W'(period_q);
						if (idx_active) begin
							idx_n = idx_q + INDEX_W'(1);
						end
					end else begin
						env_cnt_n = env_cnt_q - SUSTAIN_W'(1);
					end
				end
				OP_NOTE: begin
					idx_n     = '0;
					env_cnt_n = SUSTAIN_W'(period_q);
				end
				default: ;
			endcase
		end
	end

	// Timer and level registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b1;
			tone_cnt_q  <= '0;
			note_high_q <= '0;
			note_low_q  <= '0;
			note_sus_q  <= '0;
			idx_q       <= '0;
			env_cnt_q   <= SUSTAIN_W'(PERIOD_RESET);
			level_q     <= '0;
		end else begin
			phase_q    <= phase_n;
			tone_cnt_q <= tone_cnt_n;
			idx_q      <= idx_n;
			env_cnt_q  <= env_cnt_n;
			level_q    <= level_n;
			if (acc && (item.op == OP_NOTE)) begin
				note_high_q <= item.high_count;
				note_low_q  <= item.low_count;
				note_sus_q  <= item.sustain_ticks;
			end
		end
	end

	// Envelope table, read at the next index and the entry after it.
	estp_env_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_env_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (acc && (item.op == OP_WRITE)),
		.waddr     (item.entry_addr),
		.wentry    ('{marker: item.entry_marker, level: item.entry_level}),
		.raddr_cur ({1'b0, idx_n}),
		.raddr_nxt ({1'b0, idx_n} + RADDR_W'(1)),
		.rd        (pair)
	);

	// Every item reports the state it leaves behind.
	assign res_n.dac_level         = level_n;
	assign res_n.tone_high         = !phase_n;
	assign res_n.envelope_position = idx_n;

	estp_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (acc),
		.push_data    (res_n),
		.push_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_note_restarts_env: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (item.op == OP_NOTE)) |=> (idx_q == '0) && (env_cnt_q == SUSTAIN_W'(period_q)))
		else $error("note start did not restart the envelope");

	a_non_tick_keeps_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (item.op != OP_TICK)) |=> $stable(tone_cnt_q) && $stable(phase_q)
			&& $stable(level_q))
		else $error("tone state changed on an item that is not a tick");
`endif

endmodule

@@ rtl/estp_env_mem.sv @@
module estp_env_mem import estp_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [EADDR_W-1:0] waddr,
	input  entry_t             wentry,
	input  logic [RADDR_W-1:0] raddr_cur,
	input  logic [RADDR_W-1:0] raddr_nxt,
	output env_pair_t          rd
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned XW = (AW + 1 > RADDR_W) ? AW + 1 : RADDR_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];

	logic [XW-1:0] waddr_x;
	logic [XW-1:0] rcur_x;
	logic [XW-1:0] rnxt_x;
	logic          wr_ok;
	logic          cur_ok;
	logic          nxt_ok;
	logic          cur_ok_q;
	logic          nxt_ok_q;
	entry_t        cur_q;
	entry_t        nxt_q;

	assign waddr_x = XW'(waddr);
	assign rcur_x  = XW'(raddr_cur);
	assign rnxt_x  = XW'(raddr_nxt);
	assign wr_ok   = we && (waddr_x < DEPTH_X);
	assign cur_ok  = rcur_x < DEPTH_X;
	assign nxt_ok  = rnxt_x < DEPTH_X;

	// Table write port; addresses past the table are dropped.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[waddr_x[AW-1:0]] <= wentry;
		end
	end

	// Two registered read ports. A write to the same entry in the same cycle
	// is forwarded so the next tick sees the new contents.
	always_ff @(posedge clk) begin
		if (wr_ok && (waddr_x == rcur_x)) begin
			cur_q <= wentry;
		end else begin
			cur_q <= mem[rcur_x[AW-1:0]];
		end
		if (wr_ok && (waddr_x == rnxt_x)) begin
			nxt_q <= wentry;
		end else begin
			nxt_q <= mem[rnxt_x[AW-1:0]];
		end
	end

	// Range flags; the index starts at zero, which always lies in the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ok_q <= 1'b1;
			nxt_ok_q <= 1'b1;
		end else begin
			cur_ok_q <= cur_ok;
			nxt_ok_q <= nxt_ok;
		end
	end

	// Reads past the end of the table answer as zero.
	assign rd.cur = cur_ok_q ? cur_q : '0;
	assign rd.nxt = nxt_ok_q ? nxt_q : '0;

endmodule

@@ rtl/estp_out_buf.sv @@
module estp_out_buf import estp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    push_ready,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;
	logic    pop;

	assign pop        = main_v_q && result_ready;
	assign push_ready = !skid_v_q;

	// Control: the skid slot fills only when the main slot is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload slots.
	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign result_valid = main_v_q;
	assign result       = main_q;

`ifndef NO_ASSERTIONS
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid slot holds a beat while the main slot is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(main_v_q && !result_ready && !skid_v_q && push) |=> skid_v_q)
		else $error("beat pushed during a stall was not kept in the skid slot");
`endif

endmodule
